[sv/tet_mesh_connectivity_gen_core_defines.svh]
// Assertion macros shared by the connectivity generator RTL
`ifndef TET_MESH_CONNECTIVITY_GEN_CORE_DEFINES_SVH
`define TET_MESH_CONNECTIVITY_GEN_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define TMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tmc_pkg.sv]
// Types, constants and corner tables of the tet mesh connectivity generator
package tmc_pkg;

  localparam int MAX_CELLS  = 1024;
  localparam int CW         = 11;
  localparam int NW         = 10;
  localparam int PW         = 21;
  localparam int MW         = 32;
  localparam int VW         = 31;
  localparam int EW         = 33;
  localparam int TGW        = 8;
  localparam int FUNC_W     = 3;
  localparam int FW         = 3;
  localparam int TW         = 3;
  localparam int RIDX_W     = 2;
  localparam int NFACE      = 6;
  localparam int FIFO_DEPTH = 4;

  localparam logic [FUNC_W-1:0] FUNC_NODE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_BRICK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_BOTTOM = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TOP    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LEFT   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_RIGHT  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_FRONT  = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_BACK   = 3'd7;

  localparam logic [FW-1:0] FACE_BOTTOM = 3'd0;
  localparam logic [FW-1:0] FACE_TOP    = 3'd1;
  localparam logic [FW-1:0] FACE_LEFT   = 3'd2;
  localparam logic [FW-1:0] FACE_RIGHT  = 3'd3;
  localparam logic [FW-1:0] FACE_FRONT  = 3'd4;
  localparam logic [FW-1:0] FACE_BACK   = 3'd5;

  localparam logic [RIDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [RIDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [RIDX_W-1:0] REG_CELLS_Z = 2'd2;

  localparam logic [TW-1:0] LAST_NODE  = 3'd0;
  localparam logic [TW-1:0] LAST_BRICK = 3'd4;
  localparam logic [TW-1:0] LAST_FACE  = 3'd1;

  typedef enum logic [1:0] {
    KIND_NODE,
    KIND_BRICK,
    KIND_FACE
  } kind_t;

  typedef struct packed {
    logic [CW-1:0]                 ne0;
    logic [CW-1:0]                 ne1;
    logic [CW-1:0]                 ne2;
    logic [NW-1:0]                 nm0;
    logic [NW-1:0]                 nm1;
    logic [NW-1:0]                 nm2;
    logic [PW-1:0]                 s0;
    logic [PW-1:0]                 s1;
    logic [PW-1:0]                 s2;
    logic [PW-1:0]                 p01;
    logic [NFACE-1:0][EW-1:0]      fbase;
  } cfg_t;

  typedef struct packed {
    kind_t         kind;
    logic [FW-1:0] face;
    logic          par;
    logic [VW-1:0] node0;
    logic [EW-1:0] res;
  } item_t;

  localparam logic [2:0] ROT_CORNER [8] = '{3'd2, 3'd3, 3'd6, 3'd7, 3'd0, 3'd1, 3'd4, 3'd5};

  localparam logic [2:0] TET_CORNER [5][4] = '{
    '{3'd4, 3'd5, 3'd6, 3'd0},
    '{3'd7, 3'd6, 3'd5, 3'd3},
    '{3'd2, 3'd3, 3'd0, 3'd6},
    '{3'd1, 3'd0, 3'd3, 3'd5},
    '{3'd5, 3'd0, 3'd6, 3'd3}
  };

  // [face][parity][triangle][vertex], corner bit0 axis0, bit1 axis1, bit2 axis2
  localparam logic [2:0] TRI_CORNER [6][2][2][3] = '{
    '{'{'{3'd0, 3'd3, 3'd1}, '{3'd0, 3'd2, 3'd3}}, '{'{3'd0, 3'd2, 3'd1}, '{3'd1, 3'd2, 3'd3}}},
    '{'{'{3'd4, 3'd5, 3'd6}, '{3'd5, 3'd7, 3'd6}}, '{'{3'd4, 3'd5, 3'd7}, '{3'd4, 3'd7, 3'd6}}},
    '{'{'{3'd0, 3'd4, 3'd6}, '{3'd0, 3'd6, 3'd2}}, '{'{3'd0, 3'd4, 3'd2}, '{3'd4, 3'd6, 3'd2}}},
    '{'{'{3'd1, 3'd3, 3'd5}, '{3'd3, 3'd7, 3'd5}}, '{'{3'd1, 3'd7, 3'd5}, '{3'd1, 3'd3, 3'd7}}},
    '{'{'{3'd0, 3'd1, 3'd5}, '{3'd0, 3'd5, 3'd4}}, '{'{3'd0, 3'd1, 3'd4}, '{3'd1, 3'd5, 3'd4}}},
    '{'{'{3'd2, 3'd6, 3'd3}, '{3'd6, 3'd7, 3'd3}}, '{'{3'd2, 3'd6, 3'd7}, '{3'd2, 3'd7, 3'd3}}}
  };

  localparam logic [TGW-1:0] FACE_TAG [6] = '{8'd100, 8'd200, 8'd1, 8'd2, 8'd10, 8'd20};

endpackage

[sv/tmc_intf.sv]
// Channel interfaces: item input, result output and register write
interface tmc_in_if import tmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CW-1:0]     ix;
  logic [CW-1:0]     iy;
  logic [CW-1:0]     iz;

  modport source (output valid, func, ix, iy, iz, input ready);
  modport sink   (input valid, func, ix, iy, iz, output ready);
endinterface

interface tmc_out_if import tmc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [EW-1:0]  elem_id;
  logic [TGW-1:0] tag;
  logic [VW-1:0]  vert_a;
  logic [VW-1:0]  vert_b;
  logic [VW-1:0]  vert_c;
  logic [VW-1:0]  vert_d;
  logic           last;

  modport source (output valid, elem_id, tag, vert_a, vert_b, vert_c, vert_d, last,
                  input ready);
  modport sink   (input valid, elem_id, tag, vert_a, vert_b, vert_c, vert_d, last,
                  output ready);
endinterface

interface tmc_cfg_if import tmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RIDX_W-1:0] idx;
  logic [CW-1:0]     data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

[sv/tmc_cfg.sv]
// Register file and derived mesh constants (strides, products, face id bases)
module tmc_cfg import tmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tmc_cfg_if.sink   cfg_ch,
  output cfg_t      cfg,
  output logic      busy
);

  localparam logic [2:0] DERIVE_LAT = 3'd5;

  typedef enum logic [1:0] {
    ORD_Z,
    ORD_Y,
    ORD_X
  } ord_t;

  logic [CW-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic [2:0]    cnt_r, cnt_nxt;

  logic [CW-1:0] ne0_r, ne1_r, ne2_r;
  logic [CW-1:0] n0, n1, n2;
  logic [CW-1:0] n0_r, n1_r, n2_r;
  logic [NW-1:0] nm0_r, nm1_r, nm2_r;
  logic [PW-1:0] n01_r, n02_r, n12_r;
  logic [PW-1:0] p01_r, p12_r, p02_r;
  ord_t          ord_nxt, ord_r;
  logic [PW-1:0] s0_r, s1_r, s2_r;
  logic [VW-1:0] q_r;
  logic [EW-1:0] tot_r, o2_r;
  logic [NFACE-1:0][EW-1:0] fbase_r;

  function automatic logic [CW-1:0] eff_cells(input logic [CW-1:0] v);
    if (v == '0) begin
      return CW'(1);
    end
    if (v > CW'(MAX_CELLS)) begin
      return CW'(MAX_CELLS);
    end
    return v;
  endfunction

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cnt_nxt = (cnt_r != '0) ? cnt_r - 3'd1 : cnt_r;
    if (cfg_ch.valid) begin
      cnt_nxt = DERIVE_LAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= CW'(1);
      cells_y_r <= CW'(1);
      cells_z_r <= CW'(1);
      cnt_r     <= DERIVE_LAT;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.idx)
          REG_CELLS_X: cells_x_r <= cfg_ch.data;
          REG_CELLS_Y: cells_y_r <= cfg_ch.data;
          REG_CELLS_Z: cells_z_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    n0 = ne0_r + CW'(1);
    n1 = ne1_r + CW'(1);
    n2 = ne2_r + CW'(1);
    if (n2 >= n0 && n2 >= n1) begin
      ord_nxt = ORD_Z;
    end else if (n1 >= n0) begin
      ord_nxt = ORD_Y;
    end else begin
      ord_nxt = ORD_X;
    end
  end

  always_ff @(posedge clk) begin
    ne0_r <= eff_cells(cells_x_r);
    ne1_r <= eff_cells(cells_y_r);
    ne2_r <= eff_cells(cells_z_r);

    n0_r  <= n0;
    n1_r  <= n1;
    n2_r  <= n2;
    nm0_r <= NW'(ne0_r - CW'(1));
    nm1_r <= NW'(ne1_r - CW'(1));
    nm2_r <= NW'(ne2_r - CW'(1));
    n01_r <= PW'(PW'(n0) * PW'(n1));
    n02_r <= PW'(PW'(n0) * PW'(n2));
    n12_r <= PW'(PW'(n1) * PW'(n2));
    p01_r <= PW'(PW'(ne0_r) * PW'(ne1_r));
    p12_r <= PW'(PW'(ne1_r) * PW'(ne2_r));
    p02_r <= PW'(PW'(ne0_r) * PW'(ne2_r));
    ord_r <= ord_nxt;

    unique case (ord_r)
      ORD_Z: begin
        s0_r <= PW'(1);
        s1_r <= PW'(n0_r);
        s2_r <= n01_r;
      end
      ORD_Y: begin
        s0_r <= PW'(n2_r);
        s1_r <= n02_r;
        s2_r <= PW'(1);
      end
      default: begin
        s0_r <= n12_r;
        s1_r <= PW'(1);
        s2_r <= PW'(n1_r);
      end
    endcase
    q_r <= VW'(MW'(p01_r) * MW'(ne2_r));

    tot_r <= (EW'(q_r) << 2) + EW'(q_r);
    o2_r  <= (EW'(p01_r) << 2) + (EW'(p12_r) << 2);

    fbase_r[FACE_BOTTOM] <= tot_r;
    fbase_r[FACE_TOP]    <= tot_r + (EW'(p01_r) << 1);
    fbase_r[FACE_LEFT]   <= tot_r + (EW'(p01_r) << 2);
    fbase_r[FACE_RIGHT]  <= tot_r + (EW'(p01_r) << 2) + (EW'(p12_r) << 1);
    fbase_r[FACE_FRONT]  <= tot_r + o2_r;
    fbase_r[FACE_BACK]   <= tot_r + o2_r + (EW'(p02_r) << 1);
  end

  assign busy = (cnt_r != '0);

  always_comb begin
    cfg.ne0   = ne0_r;
    cfg.ne1   = ne1_r;
    cfg.ne2   = ne2_r;
    cfg.nm0   = nm0_r;
    cfg.nm1   = nm1_r;
    cfg.nm2   = nm2_r;
    cfg.s0    = s0_r;
    cfg.s1    = s1_r;
    cfg.s2    = s2_r;
    cfg.p01   = p01_r;
    cfg.fbase = fbase_r;
  end

endmodule

[sv/tmc_front.sv]
// Front pipeline: accept, classify, and compute base node id and element id
module tmc_front import tmc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  tmc_in_if.sink  in_ch,
  input  cfg_t    cfg,
  input  logic    cfg_busy,
  output item_t   push_item,
  output logic    push,
  input  logic    full
);

  typedef struct packed {
    kind_t         kind;
    logic [FW-1:0] face;
    logic          par;
    logic          sc5;
  } meta_t;

  typedef struct packed {
    meta_t         m;
    logic [CW-1:0] a0;
    logic [CW-1:0] a1;
    logic [CW-1:0] a2;
    logic [NW-1:0] u;
    logic [NW-1:0] v;
    logic [NW-1:0] w;
    logic [CW-1:0] k;
  } s1_t;

  logic          adv, acc;
  logic          v1_r, v2_r, v3_r, v4_r;
  logic [NW-1:0] cx, cy, cz;
  logic [CW-1:0] ax, ay, az;
  s1_t           s1_nxt, s1_r;
  meta_t         m2_r, m3_r;
  logic [NW-1:0] u2_r;
  logic [VW-1:0] pm0_r, pm1_r, pm2_r, r2_r;
  logic [PW-1:0] r1_r;
  logic [VW-1:0] node3_r, lin3_r;
  logic [EW-1:0] lin_scl, base_sel;
  item_t         item4_nxt, item4_r;

  assign adv         = !v4_r || !full;
  assign in_ch.ready = adv && !cfg_busy;
  assign acc         = in_ch.valid && in_ch.ready;
  assign push        = v4_r && !full;
  assign push_item   = item4_r;

  always_comb begin
    cx = (in_ch.ix > CW'(cfg.nm0)) ? cfg.nm0 : in_ch.ix[NW-1:0];
    cy = (in_ch.iy > CW'(cfg.nm1)) ? cfg.nm1 : in_ch.iy[NW-1:0];
    cz = (in_ch.iz > CW'(cfg.nm2)) ? cfg.nm2 : in_ch.iz[NW-1:0];
    ax = (in_ch.ix > cfg.ne0) ? cfg.ne0 : in_ch.ix;
    ay = (in_ch.iy > cfg.ne1) ? cfg.ne1 : in_ch.iy;
    az = (in_ch.iz > cfg.ne2) ? cfg.ne2 : in_ch.iz;

    s1_nxt        = '0;
    s1_nxt.m.kind = KIND_FACE;
    unique case (in_ch.func)
      FUNC_NODE: begin
        s1_nxt.m.kind = KIND_NODE;
        s1_nxt.a0     = ax;
        s1_nxt.a1     = ay;
        s1_nxt.a2     = az;
      end
      FUNC_BRICK: begin
        s1_nxt.m.kind = KIND_BRICK;
        s1_nxt.m.sc5  = 1'b1;
        s1_nxt.m.par  = cx[0] ^ cy[0] ^ cz[0];
        s1_nxt.a0     = CW'(cx);
        s1_nxt.a1     = CW'(cy);
        s1_nxt.a2     = CW'(cz);
        s1_nxt.u      = cx;
        s1_nxt.v      = cy;
        s1_nxt.k      = cfg.ne0;
        s1_nxt.w      = cz;
      end
      FUNC_BOTTOM, FUNC_TOP: begin
        s1_nxt.m.face = (in_ch.func == FUNC_TOP) ? FACE_TOP : FACE_BOTTOM;
        s1_nxt.m.par  = cx[0] ^ cy[0] ^ ((in_ch.func == FUNC_TOP) & cfg.nm2[0]);
        s1_nxt.a0     = CW'(cx);
        s1_nxt.a1     = CW'(cy);
        s1_nxt.a2     = (in_ch.func == FUNC_TOP) ? CW'(cfg.nm2) : '0;
        s1_nxt.u      = cx;
        s1_nxt.v      = cy;
        s1_nxt.k      = cfg.ne0;
      end
      FUNC_LEFT, FUNC_RIGHT: begin
        s1_nxt.m.face = (in_ch.func == FUNC_RIGHT) ? FACE_RIGHT : FACE_LEFT;
        s1_nxt.m.par  = cy[0] ^ cz[0] ^ ((in_ch.func == FUNC_RIGHT) & cfg.nm0[0]);
        s1_nxt.a0     = (in_ch.func == FUNC_RIGHT) ? CW'(cfg.nm0) : '0;
        s1_nxt.a1     = CW'(cy);
        s1_nxt.a2     = CW'(cz);
        s1_nxt.u      = cy;
        s1_nxt.v      = cz;
        s1_nxt.k      = cfg.ne1;
      end
      default: begin
        s1_nxt.m.face = (in_ch.func == FUNC_BACK) ? FACE_BACK : FACE_FRONT;
        s1_nxt.m.par  = cx[0] ^ cz[0] ^ ((in_ch.func == FUNC_BACK) & cfg.nm1[0]);
        s1_nxt.a0     = CW'(cx);
        s1_nxt.a1     = (in_ch.func == FUNC_BACK) ? CW'(cfg.nm1) : '0;
        s1_nxt.a2     = CW'(cz);
        s1_nxt.u      = cz;
        s1_nxt.v      = cx;
        s1_nxt.k      = cfg.ne2;
      end
    endcase
  end

  always_comb begin
    lin_scl  = m3_r.sc5 ? (EW'(lin3_r) << 2) + EW'(lin3_r) : EW'(lin3_r) << 1;
    base_sel = (m3_r.kind == KIND_FACE) ? cfg.fbase[m3_r.face] : '0;
    item4_nxt.kind  = m3_r.kind;
    item4_nxt.face  = m3_r.face;
    item4_nxt.par   = m3_r.par;
    item4_nxt.node0 = node3_r;
    item4_nxt.res   = lin_scl + base_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= s1_nxt;

      m2_r    <= s1_r.m;
      u2_r    <= s1_r.u;
      pm0_r   <= VW'(MW'(cfg.s0) * MW'(s1_r.a0));
      pm1_r   <= VW'(MW'(cfg.s1) * MW'(s1_r.a1));
      pm2_r   <= VW'(MW'(cfg.s2) * MW'(s1_r.a2));
      r1_r    <= PW'(PW'(s1_r.k) * PW'(s1_r.v));
      r2_r    <= VW'(MW'(cfg.p01) * MW'(s1_r.w));

      m3_r    <= m2_r;
      node3_r <= pm0_r + pm1_r + pm2_r;
      lin3_r  <= VW'(u2_r) + VW'(r1_r) + r2_r;

      item4_r <= item4_nxt;
    end
  end

endmodule

[sv/tmc_fifo.sv]
// Item queue between the front pipeline and the result sequencer
module tmc_fifo import tmc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            q_mem_r [FIFO_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[sv/tmc_back.sv]
// Result sequencer: expand one queued item into node, tetrahedron or triangle results
module tmc_back import tmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  item_t     head,
  input  logic      empty,
  output logic      pop,
  output logic      busy,
  tmc_out_if.source out_ch
);

  logic           wv_r;
  item_t          w_r;
  logic [TW-1:0]  t_r;
  logic [TW-1:0]  last_t;
  logic           out_free, emit, finish;
  logic [2:0]     code [4];
  logic           use_bcd, use_d;

  logic           out_v_r;
  logic [EW-1:0]  elem_r;
  logic [TGW-1:0] tag_r;
  logic [VW-1:0]  va_r, vb_r, vc_r, vd_r;
  logic           last_r;
  logic [TGW-1:0] tag_nxt;

  function automatic logic [VW-1:0] corner_id(input logic [VW-1:0] n0,
                                              input logic [2:0]    c,
                                              input cfg_t          cf);
    return n0 + (c[0] ? VW'(cf.s0) : '0) + (c[1] ? VW'(cf.s1) : '0)
              + (c[2] ? VW'(cf.s2) : '0);
  endfunction

  always_comb begin
    code[0] = 3'd0;
    code[1] = 3'd0;
    code[2] = 3'd0;
    code[3] = 3'd0;
    use_bcd = 1'b0;
    use_d   = 1'b0;
    last_t  = LAST_NODE;
    tag_nxt = '0;
    unique case (w_r.kind)
      KIND_BRICK: begin
        use_bcd = 1'b1;
        use_d   = 1'b1;
        last_t  = LAST_BRICK;
        for (int k = 0; k < 4; k++) begin
          code[k] = w_r.par ? ROT_CORNER[TET_CORNER[t_r][k]] : TET_CORNER[t_r][k];
        end
      end
      KIND_FACE: begin
        use_bcd = 1'b1;
        last_t  = LAST_FACE;
        tag_nxt = FACE_TAG[w_r.face];
        for (int k = 0; k < 3; k++) begin
          code[k] = TRI_CORNER[w_r.face][w_r.par][t_r[0]][k];
        end
      end
      default: ;
    endcase
  end

  assign out_free = !out_v_r || out_ch.ready;
  assign emit     = wv_r && out_free;
  assign finish   = emit && (t_r == last_t);
  assign pop      = !empty && (!wv_r || finish);
  assign busy     = wv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r    <= 1'b0;
      t_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (pop) begin
        wv_r <= 1'b1;
        t_r  <= '0;
      end else if (finish) begin
        wv_r <= 1'b0;
      end else if (emit) begin
        t_r <= t_r + TW'(1);
      end
      if (out_free) begin
        out_v_r <= wv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_r <= head;
    end
    if (emit) begin
      elem_r <= w_r.res + EW'(t_r);
      tag_r  <= tag_nxt;
      va_r   <= corner_id(w_r.node0, code[0], cfg);
      vb_r   <= use_bcd ? corner_id(w_r.node0, code[1], cfg) : '0;
      vc_r   <= use_bcd ? corner_id(w_r.node0, code[2], cfg) : '0;
      vd_r   <= use_d ? corner_id(w_r.node0, code[3], cfg) : '0;
      last_r <= (t_r == last_t);
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.elem_id = elem_r;
  assign out_ch.tag     = tag_r;
  assign out_ch.vert_a  = va_r;
  assign out_ch.vert_b  = vb_r;
  assign out_ch.vert_c  = vc_r;
  assign out_ch.vert_d  = vd_r;
  assign out_ch.last    = last_r;

endmodule

[sv/tet_mesh_connectivity_gen_core.sv]
// Top level of the structured brick mesh connectivity generator
//
// Channels: in_ch takes one request per transfer (func selects node, brick
// or one of six boundary faces; ix, iy, iz give the node or cell indices).
// out_ch returns the results of each request in order, last set on the final
// one: one result for a node, five tetrahedra for a brick, two triangles for
// a face cell. cfg_ch writes cells_x, cells_y, cells_z at index 0, 1, 2.
// The first result of a request passes the front stages, the queue, the
// sequencer's work register and the result register. Throughput: one result
// per cycle while out_ch is ready. Requests enter every cycle, unless a stall
// or a register write holds in_ch.ready low, through a 4-stage front
// pipeline and a 4-entry queue; the output sequencer sets the sustained rate.
// After reset and after every register write, in_ch.ready stays low while
// strides and face id bases are recomputed; cfg_ch is always ready.
// Registers reset to one brick per axis.
// When out_ch stalls, the result register holds and the queue fills; with the
// queue full and an item in the last front stage, in_ch.ready drops.
`include "tet_mesh_connectivity_gen_core_defines.svh"

module tet_mesh_connectivity_gen_core import tmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tmc_in_if.sink    in_ch,
  tmc_out_if.source out_ch,
  tmc_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  logic  cfg_busy;
  item_t q_in, q_head;
  logic  q_push, q_pop, q_full, q_empty;
  logic  bk_busy;

  tmc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg),
    .busy   (cfg_busy)
  );

  tmc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .cfg_busy  (cfg_busy),
    .push_item (q_in),
    .push      (q_push),
    .full      (q_full)
  );

  tmc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tmc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .busy   (bk_busy),
    .out_ch (out_ch)
  );

  `TMC_ASSERT_NXT(a_cfg_holds_input, cfg_ch.valid && cfg_ch.ready, !in_ch.ready, "input taken while constants settle")
  `TMC_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "queue popped while empty")
  `TMC_ASSERT_IMP(a_tail_pending, out_ch.valid && !out_ch.last, bk_busy, "results missing after a non-final result")

endmodule
